// ----- design/stk_pkg.sv -----
// Shared types and constants for the stack with insert and erase.
package stk_pkg;

    // Default number of entries.
    localparam int unsigned DEPTH_DEF = 64;

    // Fixed field widths.
    localparam int unsigned VAL_W = 32;
    localparam int unsigned POS_W = 7;
    localparam int unsigned CNT_W = 7;

    // Operation codes of a request.
    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_ERASE  = 2'd2,
        OP_INSERT = 2'd3
    } t_op;

    // Status codes of a result.
    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_NOTFOUND = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESULT
    } t_state;

    // Control broadcast from the controller to every cell.
    typedef struct packed {
        logic              capture;
        logic              erase;
        logic              insert;
        logic [VAL_W-1:0]  value;
    } t_cell_ctl;

endpackage

// ----- design/stk_cell.sv -----
// One stack cell: holds one entry, compares it and shifts with its neighbors.
module stk_cell import stk_pkg::*; #(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 7
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [CW-1:0]    i_count,
    input  logic [CW-1:0]    i_at,
    input  logic [VAL_W-1:0] i_upper,
    input  logic [VAL_W-1:0] i_lower,
    input  logic             i_above,
    output logic [VAL_W-1:0] o_data,
    output logic             o_below
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [VAL_W-1:0] r_data;
    logic             r_match;
    logic             w_valid;

    assign w_valid = (MY_IDX < i_count);

    // Capture the compare on request, then shift or load on update.
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= w_valid && (r_data == i_ctl.value);
        end
        if (i_ctl.erase) begin
            // Cells at or above the topmost match take the word above them.
            if (!i_above) begin
                r_data <= i_upper;
            end
        end else if (i_ctl.insert) begin
            if (MY_IDX > i_at) begin
                r_data <= i_lower;
            end else if (MY_IDX == i_at) begin
                r_data <= i_ctl.value;
            end
        end
    end

    // A match anywhere at or above this cell travels down the row.
    assign o_below = i_above | r_match;
    assign o_data  = r_data;

endmodule

// ----- design/stack_with_insert_and_erase.sv -----
// Top level of the bounded stack with positional insert and search erase.
//
//  channel   | signals                                     | handshake
//  ----------+---------------------------------------------+----------------------
//  request   | i_operation, i_value, i_position            | start high, busy low
//  result    | o_status, o_entry_count, o_top_value        | o_valid, one cycle
//
// For every request, at the accepting edge every cell compares its entry with
// the request word, and at the next edge the row of cells shifts or loads in
// parallel. The result is shown in the cycle after that, while a new
// request may already be accepted. Reset clears the entry count and the
// controller; entries stay unknown until written. The receiver cannot stall.
module stack_with_insert_and_erase import stk_pkg::*; #(
    parameter int unsigned DEPTH = DEPTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_operation,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic [POS_W-1:0]        i_position,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [CNT_W-1:0]        o_entry_count,
    output logic signed [VAL_W-1:0] o_top_value
);

    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_state           r_state, n_state;
    logic [CW-1:0]    r_count, n_count;
    t_op              r_op;
    logic [VAL_W-1:0] r_value;
    logic [POS_W-1:0] r_position;
    t_status          r_status, n_status;

    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic             w_exec;
    logic [CW-1:0]    w_at;
    logic             w_found;
    logic             w_full;
    logic             w_empty;
    logic [VAL_W-1:0] w_data [DEPTH];
    logic             w_above [DEPTH+1];
    logic [VAL_W-1:0] w_top;

    assign w_accept = start && !busy;
    assign w_exec   = (r_state == S_EXEC);
    assign w_full   = (r_count == FULL_CNT);
    assign w_empty  = (r_count == '0);
    assign w_found  = w_above[0];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) n_state = S_EXEC;
            S_EXEC:   n_state = S_RESULT;
            S_RESULT: n_state = start ? S_EXEC : S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Handshake outputs.
    always_comb begin
        busy    = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            S_IDLE:   ;
            S_EXEC:   busy = 1'b1;
            S_RESULT: o_valid = 1'b1;
            default:  ;
        endcase
    end

    // Latch the request.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= t_op'(i_operation);
            r_value    <= i_value;
            r_position <= i_position;
        end
    end

    // Insert point: a push lands on top, an insert at min(position, count).
    always_comb begin
        w_at = r_count;
        if (r_op == OP_INSERT && (32'(r_position) < 32'(r_count))) begin
            w_at = CW'(r_position);
        end
    end

    // Cell control, status and new count for the update cycle.
    always_comb begin
        w_ctl.capture = w_accept;
        w_ctl.value   = w_accept ? i_value : r_value;
        w_ctl.erase   = 1'b0;
        w_ctl.insert  = 1'b0;
        n_status      = STAT_OK;
        n_count       = r_count;
        unique case (r_op)
            OP_PUSH, OP_INSERT: begin
                if (w_full) begin
                    n_status = STAT_FULL;
                end else begin
                    w_ctl.insert = w_exec;
                    n_count      = r_count + 1'b1;
                end
            end
            OP_POP: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else begin
                    n_count = r_count - 1'b1;
                end
            end
            OP_ERASE: begin
                if (w_empty) begin
                    n_status = STAT_EMPTY;
                end else if (!w_found) begin
                    n_status = STAT_NOTFOUND;
                end else begin
                    w_ctl.erase = w_exec;
                    n_count     = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_exec) begin
                r_count <= n_count;
            end
        end
    end

    // Status of the request just executed.
    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status <= n_status;
        end
    end

    // The row of cells; the top cell sees no match above it.
    assign w_above[DEPTH] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        stk_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_count (r_count),
            .i_at    (w_at),
            .i_upper (w_data[(g == DEPTH - 1) ? g : g + 1]),
            .i_lower (w_data[(g == 0) ? g : g - 1]),
            .i_above (w_above[g+1]),
            .o_data  (w_data[g]),
            .o_below (w_above[g])
        );
    end

    // The top entry is the cell just below the count; none when empty.
    always_comb begin
        w_top = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (CW'(i + 1) == r_count) begin
                w_top = w_top | w_data[i];
            end
        end
    end

    assign o_status      = r_status;
    assign o_entry_count = CNT_W'(r_count);
    assign o_top_value   = w_top;

endmodule

// ----- design/stk_checker.sv -----
// Port-level checks for the stack, bound to the top level.
module stk_checker import stk_pkg::*; (
    input logic                    i_clk,
    input logic                    i_rst_n,
    input logic                    start,
    input logic                    busy,
    input logic                    o_valid,
    input logic [1:0]              o_status,
    input logic [CNT_W-1:0]        o_entry_count,
    input logic signed [VAL_W-1:0] o_top_value
);

    // An accepted request always makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not make the block busy");

    // Each busy cycle is followed by a result, with the block no longer busy.
    a_busy_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_valid && !busy))
        else $error("busy cycle not followed by a result");

    // A result is never shown while busy.
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result shown while busy");

    // An empty stack reports a zero top word.
    a_empty_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_entry_count == '0) |-> (o_top_value == '0))
        else $error("empty stack with nonzero top word");

    // A request refused for an empty stack leaves the stack empty.
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == STAT_EMPTY) |-> (o_entry_count == '0))
        else $error("empty status with a nonzero entry count");

endmodule

bind stack_with_insert_and_erase stk_checker u_stk_checker (.*);
